/* rtl/gpnm_pkg.sv */
// ----------------------------------------------------------------------------
// Grey palette nearest match: shared package
// Types, constants and helper functions used by the front end, the queue
// and the scan engine.
// ----------------------------------------------------------------------------
package gpnm_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int IDX_W       = $clog2(PAL_ENTRIES);
    localparam int RGB_W       = 24;
    localparam int DIST_W      = 10;
    localparam int SUM_W       = 15;

    localparam int LUM_R_WEIGHT = 21;
    localparam int LUM_G_WEIGHT = 72;
    localparam int LUM_B_WEIGHT = 7;
    localparam int LUM_DIVISOR  = 100;
    localparam int LUM_SHIFT    = 19;
    localparam int LUM_RECIP    = ((1 << LUM_SHIFT) + LUM_DIVISOR - 1) / LUM_DIVISOR;
    localparam int PROD_W       = 28;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_FINISH
    } bk_state_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  entry_index;
        logic [15:0] entry_color;
        logic [15:0] pixel_color;
    } req_t;

    typedef struct packed {
        logic [7:0]        match_index;
        logic [DIST_W-1:0] match_distance;
    } rsp_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       index;
        logic [RGB_W-1:0] data;
    } q_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } bk_status_t;

    function automatic logic [RGB_W-1:0] expand565(input logic [15:0] c);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = c[15:11];
        g6 = c[10:5];
        b5 = c[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/gpnm_front.sv */
// ----------------------------------------------------------------------------
// Grey palette nearest match: front end
// Accepts requests, drops loads outside the palette, expands colours and
// works out the grey level of a pixel before queueing the work.
// ----------------------------------------------------------------------------
module gpnm_front
    import gpnm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_t      req_data,
    input  q_status_t q_stat,
    output logic      q_push,
    output q_item_t   q_push_item
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    op_t              s1_op_reg;
    logic [7:0]       s1_index_reg;
    logic [RGB_W-1:0] s1_rgb_reg;
    logic [SUM_W-1:0] s1_sum_reg;

    logic             take;
    logic             keep;
    logic [RGB_W-1:0] pix_rgb;
    logic [SUM_W-1:0] sum_next;
    logic [PROD_W-1:0] lum_prod;

    assign req_stall = s1_valid_reg && q_stat.full;
    assign take      = req_valid && !req_stall;
    assign keep      = (op_t'(req_data.req_type) == OP_CONVERT)
                    || ({1'b0, req_data.entry_index} < 9'(PAL_ENTRIES));
    assign q_push    = s1_valid_reg && !q_stat.full;

    always_comb
    begin
        pix_rgb  = expand565(req_data.pixel_color);
        sum_next = SUM_W'(pix_rgb[23:16]) * SUM_W'(LUM_R_WEIGHT)
                 + SUM_W'(pix_rgb[15:8])  * SUM_W'(LUM_G_WEIGHT)
                 + SUM_W'(pix_rgb[7:0])   * SUM_W'(LUM_B_WEIGHT);
    end

    // The grey level is the weighted sum divided by the divisor, done as a
    // multiplication by a scaled reciprocal that is exact over the whole range.
    assign lum_prod = PROD_W'(s1_sum_reg) * PROD_W'(LUM_RECIP);

    always_comb
    begin
        q_push_item.op    = s1_op_reg;
        q_push_item.index = s1_index_reg;
        if (s1_op_reg == OP_LOAD)
        begin
            q_push_item.data = s1_rgb_reg;
        end
        else
        begin
            q_push_item.data = {16'd0, lum_prod[LUM_SHIFT+7:LUM_SHIFT]};
        end
    end

    always_comb
    begin
        if (take)
        begin
            s1_valid_next = keep;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg    <= op_t'(req_data.req_type);
            s1_index_reg <= req_data.entry_index;
            s1_rgb_reg   <= expand565(req_data.entry_color);
            s1_sum_reg   <= sum_next;
        end
    end

endmodule

/* rtl/gpnm_queue.sv */
// ----------------------------------------------------------------------------
// Grey palette nearest match: work queue
// A short first-in first-out queue between the front end and the scan engine.
// ----------------------------------------------------------------------------
module gpnm_queue
    import gpnm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_item_t   push_item,
    input  logic      pop,
    output q_item_t   head_item,
    output q_status_t stat
);

    q_item_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/gpnm_back.sv */
// ----------------------------------------------------------------------------
// Grey palette nearest match: scan engine
// Holds the palette, writes loaded entries and scans every entry, one per
// cycle, for the least distance to the grey level of a pixel.
// ----------------------------------------------------------------------------
module gpnm_back
    import gpnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_stat,
    input  q_item_t    q_head,
    output logic       q_pop,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp_data,
    output bk_status_t stat
);

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PAL_ENTRIES - 1);

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [RGB_W-1:0]       palette_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] entry_ok_reg;

    logic [IDX_W-1:0]  scan_addr_reg;
    logic [7:0]        lum_reg;
    logic              cmp_valid_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [RGB_W-1:0]  rd_data_reg;
    logic              rd_ok_reg;
    logic              first_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;

    logic              mem_we;
    logic              scan_start;
    logic              rd_en;
    logic              out_load;
    logic [RGB_W-1:0]  entry;
    logic [DIST_W-1:0] cand_dist;
    logic              better;

    assign stat.busy = (state_reg != BK_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_stat.valid && q_head.op == OP_CONVERT)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        scan_start = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_stat.valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.op == OP_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                    end
                end
            end
            BK_SCAN:
            begin
                rd_en = 1'b1;
            end
            BK_DRAIN:
            begin
            end
            BK_FINISH:
            begin
                out_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    // An entry that has never been written reads as zero.
    always_comb
    begin
        entry     = rd_ok_reg ? rd_data_reg : '0;
        cand_dist = DIST_W'(absdiff8(lum_reg, entry[23:16]))
                  + DIST_W'(absdiff8(lum_reg, entry[15:8]))
                  + DIST_W'(absdiff8(lum_reg, entry[7:0]));
        better    = first_reg || (cand_dist < best_dist_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            entry_ok_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= rd_en;
            if (mem_we)
            begin
                entry_ok_reg[q_head.index[IDX_W-1:0]] <= 1'b1;
            end
            if (scan_start)
            begin
                first_reg <= 1'b1;
            end
            else if (cmp_valid_reg)
            begin
                first_reg <= 1'b0;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[q_head.index[IDX_W-1:0]] <= q_head.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[scan_addr_reg];
            rd_ok_reg   <= entry_ok_reg[scan_addr_reg];
            cmp_idx_reg <= scan_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            scan_addr_reg <= '0;
            lum_reg       <= q_head.data[7:0];
        end
        else if (rd_en)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (cmp_valid_reg && better)
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= cmp_idx_reg;
        end
        if (out_load)
        begin
            rsp_data_reg.match_index    <= 8'(best_idx_reg);
            rsp_data_reg.match_distance <= best_dist_reg;
        end
    end

endmodule

/* rtl/gray_palette_nearest_match_core.sv */
// ----------------------------------------------------------------------------
// Grey palette nearest match: top level
// Finds the palette entry nearest to the grey level of an RGB565 pixel.
//
//   Channel  Signals                        Carries
//   request  req_valid, req_stall, req_data  palette loads and pixel conversions
//   result   rsp_valid, rsp_stall, rsp_data  nearest entry index and distance
//
// A load transfer passes through the front-end register and the queue before
// it is written to the palette. A conversion holds the scan engine while it
// reads through the single read port of the palette memory, once per entry.
// Reset clears the palette to zero at once through per-entry valid bits.
// A stalled result holds the scan engine, and the queue then fills and
// stalls the request side.
// ----------------------------------------------------------------------------
module gray_palette_nearest_match_core
    import gpnm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    q_status_t  q_stat;
    bk_status_t bk_stat;
    logic       q_push;
    q_item_t    q_push_item;
    logic       q_pop;
    q_item_t    q_head;

    gpnm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_push_item (q_push_item)
    );

    gpnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    gpnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .stat      (bk_stat)
    );

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.match_distance <= 10'd765))
        else $error("Result distance exceeds the largest possible sum.");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.valid)
        else $error("Queue reports full without a head item.");

    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(bk_stat.busy))
        else $error("Result appeared without a scan in progress.");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("Scan engine took an item from an empty queue.");

endmodule
